// ===== design/assert_macros.svh =====
// Assertion macros shared by the monitor RTL.
// Each macro wraps one clocked concurrent assertion that is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at each rising edge of clk_i while rst_ni is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that trig implies cons on the following edge.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ddm_pkg.sv =====
// Types and constants of the drowsiness and distraction monitor.
// Depends on nothing; imported by the monitor core.
`default_nettype none
package ddm_pkg;

  localparam int DefCountWidth = 16;
  localparam int DefTimeWidth  = 32;
  localparam int SecWidth      = 32;
  localparam int SecBitWidth   = 5;
  localparam int WinWidth      = 12;
  localparam int ThrWidth      = 8;
  localparam int CfgAddrWidth  = 5;
  localparam int CfgDataWidth  = 32;

  localparam logic [1:0] GapEnd    = 2'd3;
  localparam logic [1:0] FaceNone  = 2'd0;
  localparam logic [1:0] FaceFront = 2'd1;

  localparam logic [ThrWidth-1:0] RstPerclosThr = 8'd102;
  localparam logic [ThrWidth-1:0] RstYawnThr    = 8'd51;
  localparam logic [ThrWidth-1:0] RstSideThr    = 8'd77;
  localparam logic [ThrWidth-1:0] RstYawnSec    = 8'd2;
  localparam logic [ThrWidth-1:0] RstTurnSec    = 8'd3;
  localparam logic [WinWidth-1:0] RstWindow     = 12'd60;

  // Window slots of the boundary flags, in the order the remainder unit visits them.
  localparam logic [1:0] WinTurn  = 2'd0;
  localparam logic [1:0] WinEye   = 2'd1;
  localparam logic [1:0] WinMouth = 2'd2;

  // Ratio slots visited after the counters are updated.
  localparam logic [1:0] RatRight = 2'd0;
  localparam logic [1:0] RatLeft  = 2'd1;
  localparam logic [1:0] RatBoth  = 2'd2;
  localparam logic [1:0] RatMouth = 2'd3;

  typedef enum logic [2:0] {
    REG_PERCLOS_THR = 3'd0,
    REG_YAWN_THR    = 3'd1,
    REG_SIDE_THR    = 3'd2,
    REG_YAWN_SEC    = 3'd3,
    REG_TURN_SEC    = 3'd4,
    REG_EYE_WIN     = 3'd5,
    REG_MOUTH_WIN   = 3'd6,
    REG_TURN_WIN    = 3'd7
  } reg_idx_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,
    S_SIDE  = 6'b000100,
    S_UPD   = 6'b001000,
    S_RATIO = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  typedef struct packed {
    logic yawn_event;
    logic turn_held;
    logic turn_frequent;
    logic sleepy;
    logic right_eye_heavy;
    logic left_eye_heavy;
    logic frequent_yawn;
  } result_t;

endpackage
`default_nettype wire

// ===== design/drowsiness_distraction_monitor_core.sv =====
// Drowsiness and distraction monitor: run detectors, windowed counters and ratio checks.
// Depends on ddm_pkg and assert_macros.svh.
//
// Channel   Direction  Handshake                 Payload
// in        to block   in_valid_i / in_stall_o   face_kind_i, eye, mouth flags, now_seconds_i
// out       from block out_valid_o / out_stall_i seven result flags
// config    to block   psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//
// One shared restoring remainder unit takes the timestamp modulo each of the three window
// lengths at one bit a cycle, then one shared multiplier compares the five ratios, one a
// cycle but for the counter update after the side ratio. in_stall_o is high from acceptance
// until the result is taken. Reset clears all counters and restores register defaults.
`default_nettype none
`include "assert_macros.svh"
module drowsiness_distraction_monitor_core #(
  parameter int COUNT_WIDTH = ddm_pkg::DefCountWidth,
  parameter int TIME_WIDTH  = ddm_pkg::DefTimeWidth
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [1:0]                       face_kind_i,
  input  wire logic                             right_eye_closed_i,
  input  wire logic                             left_eye_closed_i,
  input  wire logic                             mouth_open_i,
  input  wire logic [ddm_pkg::SecWidth-1:0]     now_seconds_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  yawn_event_o,
  output logic                                  turn_held_o,
  output logic                                  turn_frequent_o,
  output logic                                  sleepy_o,
  output logic                                  right_eye_heavy_o,
  output logic                                  left_eye_heavy_o,
  output logic                                  frequent_yawn_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ddm_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [ddm_pkg::CfgDataWidth-1:0] pwdata,
  output logic [ddm_pkg::CfgDataWidth-1:0]      prdata,
  output logic                                  pready
);
  import ddm_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int TW = TIME_WIDTH;
  localparam int PW = COUNT_WIDTH + ThrWidth + 1;

  typedef logic [CW-1:0] cnt_t;
  typedef logic [TW-1:0] tim_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [1:0] gap_inc(input logic [1:0] g);
    return (g == GapEnd) ? g : g + 2'd1;
  endfunction

  function automatic logic exceeds(input tim_t now, input tim_t start,
                                   input logic [ThrWidth-1:0] limit);
    tim_t d;
    d = now - start;
    return !d[TW-1] && (d > tim_t'(limit));
  endfunction

  // Configuration registers
  logic [ThrWidth-1:0] perclos_thr_q, yawn_thr_q, side_thr_q, yawn_sec_q, turn_sec_q;
  logic [WinWidth-1:0] eye_win_q, mouth_win_q, turn_win_q;
  logic                cfg_wr;
  reg_idx_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perclos_thr_q <= RstPerclosThr;
      yawn_thr_q    <= RstYawnThr;
      side_thr_q    <= RstSideThr;
      yawn_sec_q    <= RstYawnSec;
      turn_sec_q    <= RstTurnSec;
      eye_win_q     <= RstWindow;
      mouth_win_q   <= RstWindow;
      turn_win_q    <= RstWindow;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PERCLOS_THR: perclos_thr_q <= pwdata[ThrWidth-1:0];
        REG_YAWN_THR:    yawn_thr_q    <= pwdata[ThrWidth-1:0];
        REG_SIDE_THR:    side_thr_q    <= pwdata[ThrWidth-1:0];
        REG_YAWN_SEC:    yawn_sec_q    <= pwdata[ThrWidth-1:0];
        REG_TURN_SEC:    turn_sec_q    <= pwdata[ThrWidth-1:0];
        REG_EYE_WIN:     eye_win_q     <= pwdata[WinWidth-1:0];
        REG_MOUTH_WIN:   mouth_win_q   <= pwdata[WinWidth-1:0];
        REG_TURN_WIN:    turn_win_q    <= pwdata[WinWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PERCLOS_THR: prdata = CfgDataWidth'(perclos_thr_q);
      REG_YAWN_THR:    prdata = CfgDataWidth'(yawn_thr_q);
      REG_SIDE_THR:    prdata = CfgDataWidth'(side_thr_q);
      REG_YAWN_SEC:    prdata = CfgDataWidth'(yawn_sec_q);
      REG_TURN_SEC:    prdata = CfgDataWidth'(turn_sec_q);
      REG_EYE_WIN:     prdata = CfgDataWidth'(eye_win_q);
      REG_MOUTH_WIN:   prdata = CfgDataWidth'(mouth_win_q);
      REG_TURN_WIN:    prdata = CfgDataWidth'(turn_win_q);
      default:         prdata = '0;
    endcase
  end

  // Sequencer and request registers
  state_e               state_q, state_d;
  logic [1:0]           kind_q;
  logic                 rclosed_q, lclosed_q, mopen_q, new_sec_q;
  logic [SecWidth-1:0]  sec_q;
  logic [SecBitWidth-1:0] bit_q, bit_d;
  logic [1:0]           win_idx_q, win_idx_d, rat_idx_q, rat_idx_d;
  logic [WinWidth-1:0]  rem_q, rem_d, win_sel, rem_nx;
  logic [WinWidth:0]    rem_sh;
  logic [2:0]           bnd_q, bnd_d;
  result_t              res_q, res_d;

  // Tracker and counter state
  tim_t       last_second_q, last_second_d, turn_start_q, turn_start_d;
  tim_t       mouth_start_q, mouth_start_d, now_t;
  logic [1:0] last_dir_q, last_dir_d, turn_gap_q, turn_gap_d, mouth_gap_q, mouth_gap_d;
  logic       last_mopen_q, last_mopen_d;
  cnt_t       front_q, front_d, side_q, side_d, mouth_fr_q, mouth_fr_d;
  cnt_t       run_q, run_d, yawn_fr_q, yawn_fr_d;
  cnt_t       eye_closed_q [3];
  cnt_t       eye_closed_d [3];
  cnt_t       eye_total_q [3];
  cnt_t       eye_total_d [3];

  assign now_t = tim_t'(sec_q);

  // Shared remainder step: one timestamp bit a cycle against the selected window.
  always_comb begin
    case (win_idx_q)
      WinTurn: win_sel = turn_win_q;
      WinEye:  win_sel = eye_win_q;
      default: win_sel = mouth_win_q;
    endcase
    rem_sh = {rem_q, sec_q[bit_q]};
    if (rem_sh >= {1'b0, win_sel}) begin
      rem_nx = WinWidth'(rem_sh - {1'b0, win_sel});
    end else begin
      rem_nx = rem_sh[WinWidth-1:0];
    end
  end

  // Shared ratio compare: part * 256 > threshold * total.
  logic [CW:0]          tot_sel;
  cnt_t                 part_sel;
  logic [ThrWidth-1:0]  thr_sel;
  logic [PW-1:0]        prod, lhs;
  logic                 over;

  always_comb begin
    if (state_q == S_SIDE) begin
      part_sel = side_q;
      tot_sel  = {1'b0, side_q} + {1'b0, front_q};
      thr_sel  = side_thr_q;
    end else if (rat_idx_q == RatMouth) begin
      part_sel = yawn_fr_q;
      tot_sel  = {1'b0, mouth_fr_q};
      thr_sel  = yawn_thr_q;
    end else begin
      part_sel = eye_closed_q[rat_idx_q];
      tot_sel  = {1'b0, eye_total_q[rat_idx_q]};
      thr_sel  = perclos_thr_q;
    end
    prod = PW'(thr_sel) * PW'(tot_sel);
    lhs  = PW'({part_sel, 8'd0});
    over = lhs > prod;
  end

  logic front_now, ratio_en;
  assign front_now = (kind_q == FaceFront);
  assign ratio_en  = front_now && new_sec_q &&
                     ((rat_idx_q == RatMouth) ? bnd_q[WinMouth] : bnd_q[WinEye]);

  always_comb begin
    logic       mo;
    logic [1:0] g;
    state_d       = state_q;
    bit_d         = bit_q;
    win_idx_d     = win_idx_q;
    rat_idx_d     = rat_idx_q;
    rem_d         = rem_q;
    bnd_d         = bnd_q;
    res_d         = res_q;
    last_second_d = last_second_q;
    turn_start_d  = turn_start_q;
    mouth_start_d = mouth_start_q;
    last_dir_d    = last_dir_q;
    turn_gap_d    = turn_gap_q;
    mouth_gap_d   = mouth_gap_q;
    last_mopen_d  = last_mopen_q;
    front_d       = front_q;
    side_d        = side_q;
    mouth_fr_d    = mouth_fr_q;
    run_d         = run_q;
    yawn_fr_d     = yawn_fr_q;
    eye_closed_d  = eye_closed_q;
    eye_total_d   = eye_total_q;
    mo            = 1'b0;
    g             = 2'd0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d   = S_MOD;
          bit_d     = SecBitWidth'(SecWidth - 1);
          win_idx_d = WinTurn;
          rem_d     = '0;
          res_d     = '0;
        end
      end
      S_MOD: begin
        rem_d = rem_nx;
        if (bit_q == '0) begin
          bnd_d[win_idx_q] = (win_sel != '0) && (rem_nx == '0);
          rem_d = '0;
          bit_d = SecBitWidth'(SecWidth - 1);
          if (win_idx_q == WinMouth) begin
            state_d = S_SIDE;
          end else begin
            win_idx_d = win_idx_q + 2'd1;
          end
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      S_SIDE: begin
        if (kind_q != FaceNone && new_sec_q && bnd_q[WinTurn]) begin
          res_d.turn_frequent = over;
          side_d  = '0;
          front_d = '0;
        end
        state_d = S_UPD;
      end
      S_UPD: begin
        if (kind_q != FaceNone) begin
          // Head direction run with a three-frame gap debounce.
          if (last_dir_q != kind_q) begin
            if (kind_q != FaceFront) begin
              if (turn_gap_q == '0) turn_start_d = now_t;
              else turn_gap_d = '0;
            end else begin
              turn_gap_d = gap_inc(turn_gap_q);
            end
            last_dir_d = kind_q;
          end else if (kind_q != FaceFront) begin
            if (exceeds(now_t, turn_start_q, turn_sec_q)) begin
              turn_start_d = now_t;
              res_d.turn_held = 1'b1;
            end
          end else if (turn_gap_q != '0) begin
            g = gap_inc(turn_gap_q);
            turn_gap_d = (g == GapEnd) ? 2'd0 : g;
          end
          // Mouth run: a yawn ends after three closed frames.
          mo = front_now && mopen_q;
          if (last_mopen_q != mo) begin
            if (mo) begin
              if (mouth_gap_q == '0) begin
                mouth_start_d = now_t;
                run_d = sat_inc(run_q);
              end else begin
                mouth_gap_d = '0;
              end
            end else begin
              mouth_gap_d = gap_inc(mouth_gap_q);
            end
            last_mopen_d = mo;
          end else if (mo) begin
            run_d = sat_inc(run_q);
          end else if (mouth_gap_q != '0) begin
            g = gap_inc(mouth_gap_q);
            mouth_gap_d = g;
            if (g == GapEnd) begin
              if (exceeds(now_t, mouth_start_q, yawn_sec_q)) begin
                yawn_fr_d = ((({1'b0, yawn_fr_q} + {1'b0, run_q}) >> CW) != '0) ?
                            '1 : yawn_fr_q + run_q;
                res_d.yawn_event = 1'b1;
              end
              run_d       = '0;
              mouth_gap_d = '0;
            end
          end
          if (front_now) begin
            front_d    = sat_inc(front_q);
            mouth_fr_d = sat_inc(mouth_fr_q);
            for (int i = 0; i < 3; i++) begin
              eye_total_d[i] = sat_inc(eye_total_q[i]);
            end
            if (rclosed_q) eye_closed_d[0] = sat_inc(eye_closed_q[0]);
            if (lclosed_q) eye_closed_d[1] = sat_inc(eye_closed_q[1]);
            if (rclosed_q && lclosed_q) eye_closed_d[2] = sat_inc(eye_closed_q[2]);
          end else begin
            side_d = sat_inc(side_q);
          end
        end
        last_second_d = now_t;
        rat_idx_d     = RatRight;
        state_d       = S_RATIO;
      end
      S_RATIO: begin
        if (ratio_en) begin
          case (rat_idx_q)
            RatRight: res_d.right_eye_heavy = over;
            RatLeft:  res_d.left_eye_heavy  = over;
            RatBoth:  res_d.sleepy          = over;
            default:  res_d.frequent_yawn   = over;
          endcase
        end
        if (rat_idx_q == RatMouth) begin
          if (front_now && new_sec_q) begin
            if (bnd_q[WinEye]) begin
              for (int i = 0; i < 3; i++) begin
                eye_closed_d[i] = '0;
                eye_total_d[i]  = '0;
              end
            end
            if (bnd_q[WinMouth]) begin
              mouth_fr_d = '0;
              yawn_fr_d  = '0;
            end
          end
          state_d = S_DONE;
        end else begin
          rat_idx_d = rat_idx_q + 2'd1;
        end
      end
      S_DONE: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Request fields are held without reset.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      kind_q    <= face_kind_i;
      rclosed_q <= right_eye_closed_i;
      lclosed_q <= left_eye_closed_i;
      mopen_q   <= mouth_open_i;
      sec_q     <= now_seconds_i;
      new_sec_q <= (last_second_q != tim_t'(now_seconds_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      bit_q         <= '0;
      win_idx_q     <= '0;
      rat_idx_q     <= '0;
      rem_q         <= '0;
      bnd_q         <= '0;
      res_q         <= '0;
      last_second_q <= '0;
      turn_start_q  <= '0;
      mouth_start_q <= '0;
      last_dir_q    <= '0;
      turn_gap_q    <= '0;
      mouth_gap_q   <= '0;
      last_mopen_q  <= 1'b0;
      front_q       <= '0;
      side_q        <= '0;
      mouth_fr_q    <= '0;
      run_q         <= '0;
      yawn_fr_q     <= '0;
      for (int i = 0; i < 3; i++) begin
        eye_closed_q[i] <= '0;
        eye_total_q[i]  <= '0;
      end
    end else begin
      state_q       <= state_d;
      bit_q         <= bit_d;
      win_idx_q     <= win_idx_d;
      rat_idx_q     <= rat_idx_d;
      rem_q         <= rem_d;
      bnd_q         <= bnd_d;
      res_q         <= res_d;
      last_second_q <= last_second_d;
      turn_start_q  <= turn_start_d;
      mouth_start_q <= mouth_start_d;
      last_dir_q    <= last_dir_d;
      turn_gap_q    <= turn_gap_d;
      mouth_gap_q   <= mouth_gap_d;
      last_mopen_q  <= last_mopen_d;
      front_q       <= front_d;
      side_q        <= side_d;
      mouth_fr_q    <= mouth_fr_d;
      run_q         <= run_d;
      yawn_fr_q     <= yawn_fr_d;
      eye_closed_q  <= eye_closed_d;
      eye_total_q   <= eye_total_d;
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = (state_q == S_DONE);
  assign yawn_event_o      = res_q.yawn_event;
  assign turn_held_o       = res_q.turn_held;
  assign turn_frequent_o   = res_q.turn_frequent;
  assign sleepy_o          = res_q.sleepy;
  assign right_eye_heavy_o = res_q.right_eye_heavy;
  assign left_eye_heavy_o  = res_q.left_eye_heavy;
  assign frequent_yawn_o   = res_q.frequent_yawn;

  `ASSERT_CLK(a_busy_while_result, out_valid_o |-> in_stall_o, "result shown while accepting")
  `ASSERT_NEXT(a_done_from_ratio, $rose(out_valid_o), $past(state_q, 2) == S_RATIO,
               "result raised without the ratio pass")
  `ASSERT_NEXT(a_start_clears, (state_q == S_IDLE) && in_valid_i, res_q == '0,
               "result flags not cleared on a new request")
  `ASSERT_CLK(a_turn_gap_range, turn_gap_q != GapEnd, "turn gap counter left at its end value")

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for drowsiness_distraction_monitor_core.
// Depends on ddm_pkg and the core RTL; a scoreboard class predicts each frame's flags.
`timescale 1ns / 1ps

module tb;
  import ddm_pkg::*;

  class ddm_scoreboard;
    bit [7:0]  perclos_thr, yawn_thr, side_thr, yawn_secs, turn_secs;
    bit [11:0] eye_win, mouth_win, turn_win;

    bit [31:0] last_sec, turn_begin, open_begin;
    bit [1:0]  last_dir, turn_gap, mouth_gap;
    bit        last_open;
    bit [15:0] front_cnt, side_cnt, mouth_cnt, open_run, yawn_cnt;
    bit [15:0] closed_cnt[3], total_cnt[3];

    result_t   flags_q[$];
    int        errors;

    function new();
      perclos_thr = RstPerclosThr;
      yawn_thr    = RstYawnThr;
      side_thr    = RstSideThr;
      yawn_secs   = RstYawnSec;
      turn_secs   = RstTurnSec;
      eye_win     = RstWindow;
      mouth_win   = RstWindow;
      turn_win    = RstWindow;
    endfunction

    function void set_reg(reg_idx_e idx, bit [31:0] val);
      case (idx)
        REG_PERCLOS_THR: perclos_thr = val[7:0];
        REG_YAWN_THR:    yawn_thr    = val[7:0];
        REG_SIDE_THR:    side_thr    = val[7:0];
        REG_YAWN_SEC:    yawn_secs   = val[7:0];
        REG_TURN_SEC:    turn_secs   = val[7:0];
        REG_EYE_WIN:     eye_win     = val[11:0];
        REG_MOUTH_WIN:   mouth_win   = val[11:0];
        REG_TURN_WIN:    turn_win    = val[11:0];
        default: ;
      endcase
    endfunction

    function bit [15:0] sat_inc(bit [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function bit [1:0] gap_inc(bit [1:0] g);
      return (g >= GapEnd) ? GapEnd : g + 2'd1;
    endfunction

    // A negative elapsed time (clock went backwards) never exceeds a limit.
    function bit exceeds(bit [31:0] stamp, bit [31:0] start, bit [7:0] limit);
      bit [31:0] d;
      d = stamp - start;
      if (d[31]) return 1'b0;
      return d > limit;
    endfunction

    function bit ratio_over(longint unsigned part, longint unsigned total, bit [7:0] thr);
      return part * 256 > thr * total;
    endfunction

    function bit at_boundary(bit [31:0] stamp, bit [11:0] win);
      return win != 0 && (stamp % win) == 0;
    endfunction

    function bit track_direction(bit [1:0] dir, bit [31:0] stamp);
      if (last_dir != dir) begin
        if (dir != FaceFront) begin
          if (turn_gap == 0) turn_begin = stamp;
          else turn_gap = 0;
        end else begin
          turn_gap = gap_inc(turn_gap);
        end
        last_dir = dir;
      end else if (dir != FaceFront) begin
        if (exceeds(stamp, turn_begin, turn_secs)) begin
          turn_begin = stamp;
          return 1'b1;
        end
      end else if (turn_gap > 0) begin
        turn_gap = gap_inc(turn_gap);
        if (turn_gap >= GapEnd) turn_gap = 0;
      end
      return 1'b0;
    endfunction

    function bit track_mouth(bit open, bit [31:0] stamp);
      bit [16:0] sum;
      bit        ev;
      ev = 1'b0;
      if (last_open != open) begin
        if (open) begin
          if (mouth_gap == 0) begin
            open_begin = stamp;
            open_run   = sat_inc(open_run);
          end else begin
            mouth_gap = 0;
          end
        end else begin
          mouth_gap = gap_inc(mouth_gap);
        end
        last_open = open;
      end else if (open) begin
        open_run = sat_inc(open_run);
      end else if (mouth_gap > 0) begin
        mouth_gap = gap_inc(mouth_gap);
        if (mouth_gap >= GapEnd) begin
          if (exceeds(stamp, open_begin, yawn_secs)) begin
            sum      = yawn_cnt + open_run;
            yawn_cnt = sum[16] ? 16'hFFFF : sum[15:0];
            ev       = 1'b1;
          end
          open_run  = 0;
          mouth_gap = 0;
        end
      end
      return ev;
    endfunction

    function void note_request(bit [1:0] kind, bit rc, bit lc, bit mo, bit [31:0] stamp);
      result_t r;
      bit      new_sec;
      bit      shut[3];
      r       = '0;
      new_sec = last_sec != stamp;
      // The side ratio is judged before this frame is counted.
      if (kind != FaceNone && new_sec && at_boundary(stamp, turn_win)) begin
        r.turn_frequent = ratio_over(side_cnt, side_cnt + front_cnt, side_thr);
        side_cnt  = 0;
        front_cnt = 0;
      end
      if (kind == FaceFront) begin
        shut[0] = rc;
        shut[1] = lc;
        shut[2] = rc & lc;
        void'(track_direction(FaceFront, stamp));
        front_cnt = sat_inc(front_cnt);
        for (int i = 0; i < 3; i++) begin
          total_cnt[i] = sat_inc(total_cnt[i]);
          if (shut[i]) closed_cnt[i] = sat_inc(closed_cnt[i]);
        end
        mouth_cnt   = sat_inc(mouth_cnt);
        r.yawn_event = track_mouth(mo, stamp);
        if (new_sec) begin
          if (at_boundary(stamp, eye_win)) begin
            r.right_eye_heavy = ratio_over(closed_cnt[0], total_cnt[0], perclos_thr);
            r.left_eye_heavy  = ratio_over(closed_cnt[1], total_cnt[1], perclos_thr);
            r.sleepy          = ratio_over(closed_cnt[2], total_cnt[2], perclos_thr);
            for (int i = 0; i < 3; i++) begin
              closed_cnt[i] = 0;
              total_cnt[i]  = 0;
            end
          end
          if (at_boundary(stamp, mouth_win)) begin
            r.frequent_yawn = ratio_over(yawn_cnt, mouth_cnt, yawn_thr);
            mouth_cnt = 0;
            yawn_cnt  = 0;
          end
        end
      end else if (kind != FaceNone) begin
        r.turn_held  = track_direction(kind, stamp);
        r.yawn_event = track_mouth(1'b0, stamp);
        side_cnt     = sat_inc(side_cnt);
      end
      last_sec = stamp;
      flags_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      string   names[7];
      names = '{"frequent_yawn", "left_eye_heavy", "right_eye_heavy", "sleepy",
                "turn_frequent", "turn_held", "yawn_event"};
      if (flags_q.size() == 0) begin
        $display("%0t: result with no request outstanding: %b", $time, got);
        errors++;
        return;
      end
      want = flags_q.pop_front();
      for (int i = 0; i < 7; i++)
        if (want[i] !== got[i]) begin
          $display("%0t: %s expected %b actual %b", $time, names[i], want[i], got[i]);
          errors++;
        end
    endfunction

    function int pending();
      return flags_q.size();
    endfunction
  endclass

  localparam logic [1:0] FaceLeft  = 2'd2;
  localparam logic [1:0] FaceRight = 2'd3;
  localparam int         CycleLimit = 2000000;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  face_kind_i;
  logic        right_eye_closed_i, left_eye_closed_i, mouth_open_i;
  logic [31:0] now_seconds_i;
  logic        out_valid_o, out_stall_i;
  logic        yawn_event_o, turn_held_o, turn_frequent_o, sleepy_o;
  logic        right_eye_heavy_o, left_eye_heavy_o, frequent_yawn_o;
  logic        psel, penable, pwrite, pready;
  logic [CfgAddrWidth-1:0] paddr;
  logic [CfgDataWidth-1:0] pwdata, prdata;

  ddm_scoreboard sb = new();
  bit [31:0] clock_s;
  bit        no_idle;
  bit        hold_req;
  bit        hold_seen;
  int        stall_left;
  int        cycles;

  drowsiness_distraction_monitor_core DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // Several frames share a second; now and then the clock jumps or runs backwards.
  function automatic bit [31:0] advance_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) ;
    else if (r < 95) clock_s = clock_s + 1;
    else if (r < 98) clock_s = clock_s + $urandom_range(2, 5);
    else if (r < 99) clock_s = clock_s - $urandom_range(1, 3);
    else clock_s = $urandom;
    return clock_s;
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: check accepted results and drive the stall, with one long hold-off.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.yawn_event      = yawn_event_o;
      got.turn_held       = turn_held_o;
      got.turn_frequent   = turn_frequent_o;
      got.sleepy          = sleepy_o;
      got.right_eye_heavy = right_eye_heavy_o;
      got.left_eye_heavy  = left_eye_heavy_o;
      got.frequent_yawn   = frequent_yawn_o;
      sb.check_result(got);
    end
    if (hold_req && !hold_seen) begin
      hold_seen  = 1'b1;
      stall_left = 2000;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap();
    end
  end

  task automatic send(bit [1:0] kind, bit rc, bit lc, bit mo, bit [31:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    face_kind_i        <= kind;
    right_eye_closed_i <= rc;
    left_eye_closed_i  <= lc;
    mouth_open_i       <= mo;
    now_seconds_i      <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(kind, rc, lc, mo, stamp);
  endtask

  task automatic emit(bit [1:0] kind, bit rc, bit lc, bit mo);
    send(kind, rc, lc, mo, advance_clock());
  endtask

  task automatic write_reg(reg_idx_e idx, bit [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrWidth'(idx) << 2;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_all(bit [7:0] pt, bit [7:0] yt, bit [7:0] st, bit [7:0] ys,
                           bit [7:0] ts, bit [11:0] ew, bit [11:0] mw, bit [11:0] tw);
    write_reg(REG_PERCLOS_THR, 32'(pt));
    write_reg(REG_YAWN_THR, 32'(yt));
    write_reg(REG_SIDE_THR, 32'(st));
    write_reg(REG_YAWN_SEC, 32'(ys));
    write_reg(REG_TURN_SEC, 32'(ts));
    write_reg(REG_EYE_WIN, 32'(ew));
    write_reg(REG_MOUTH_WIN, 32'(mw));
    write_reg(REG_TURN_WIN, 32'(tw));
  endtask

  // Mostly well-formed yawns and head turns with random content, plus noise.
  task automatic run_random(int count);
    int n, k, seg, shut_pct;
    n = 0;
    while (n < count) begin
      seg      = $urandom_range(0, 9);
      shut_pct = $urandom_range(0, 100);
      if (seg < 4) begin
        k = $urandom_range(1, 12);
        for (int i = 0; i < k; i++) begin
          emit(FaceFront, $urandom_range(0, 99) < shut_pct,
               $urandom_range(0, 99) < shut_pct, 1'b1);
          if ($urandom_range(0, 9) == 0) begin
            emit(FaceFront, 1'b0, 1'b0, 1'b0);
            n++;
          end
        end
        n += k;
        k = $urandom_range(2, 5);
        for (int i = 0; i < k; i++)
          emit(FaceFront, $urandom_range(0, 99) < shut_pct,
               $urandom_range(0, 99) < shut_pct, 1'b0);
        n += k;
      end else if (seg < 7) begin
        k = $urandom_range(1, 15);
        for (int i = 0; i < k; i++) begin
          emit($urandom_range(0, 3) == 0 ? FaceRight : FaceLeft, 1'($urandom),
               1'($urandom), 1'($urandom));
          if ($urandom_range(0, 7) == 0) begin
            emit(FaceFront, 1'($urandom), 1'($urandom), 1'($urandom));
            n++;
          end
        end
        n += k;
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) emit(FaceFront, 1'($urandom), 1'($urandom), 1'b0);
        n += k;
      end else begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++)
          emit(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        n += k;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    face_kind_i = FaceNone;
    right_eye_closed_i = 1'b0;
    left_eye_closed_i = 1'b0;
    mouth_open_i = 1'b0;
    now_seconds_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset settings.
    send(FaceFront, 1'b0, 1'b0, 1'b0, 32'd0);
    send(FaceNone,  1'b1, 1'b1, 1'b1, 32'd5);
    send(FaceLeft,  1'b1, 1'b1, 1'b1, 32'd6);
    send(FaceRight, 1'b0, 1'b0, 1'b0, 32'd10);
    send(FaceRight, 1'b0, 1'b0, 1'b0, 32'd10);
    send(FaceFront, 1'b1, 1'b1, 1'b1, 32'd11);
    send(FaceFront, 1'b1, 1'b1, 1'b1, 32'd12);
    send(FaceFront, 1'b1, 1'b0, 1'b1, 32'd13);
    send(FaceFront, 1'b0, 1'b1, 1'b0, 32'd17);
    send(FaceFront, 1'b0, 1'b1, 1'b1, 32'd18);
    send(FaceFront, 1'b1, 1'b1, 1'b0, 32'd19);
    send(FaceFront, 1'b1, 1'b1, 1'b0, 32'd20);
    send(FaceFront, 1'b1, 1'b1, 1'b0, 32'd21);
    send(FaceFront, 1'b1, 1'b1, 1'b0, 32'd60);
    send(FaceLeft,  1'b0, 1'b0, 1'b0, 32'd120);
    send(FaceFront, 1'b0, 1'b0, 1'b0, 32'd50);
    send(FaceFront, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send(FaceFront, 1'b0, 1'b0, 1'b0, 32'd0);
    send(FaceLeft,  1'b0, 1'b0, 1'b0, 32'h8000_0000);
    send(FaceLeft,  1'b0, 1'b0, 1'b0, 32'h8000_0010);
    send(FaceLeft,  1'b0, 1'b0, 1'b0, 32'h0000_0010);
    wait_idle();

    // Lowest limits, every second a window end, no idling.
    write_all(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd1, 12'd1, 12'd1);
    no_idle = 1'b1;
    clock_s = 32'd100;
    run_random(100);
    wait_idle();
    no_idle = 1'b0;

    // Highest limits, 3600-second windows; the receiver holds off for a long stretch.
    write_all(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 12'd3600, 12'd3600, 12'd3600);
    clock_s = 32'd3600 * 1000 - 3;
    hold_req = 1'b1;
    run_random(100);
    wait_idle();

    write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 6)),
              8'($urandom_range(0, 6)), 12'($urandom_range(2, 12)),
              12'($urandom_range(2, 12)), 12'($urandom_range(2, 12)));
    run_random(120);
    wait_idle();

    // A zero window length never closes.
    write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 4)),
              8'($urandom_range(0, 4)), 12'd7, 12'd5, 12'd0);
    run_random(110);
    wait_idle();

    write_all(8'd128, 8'($urandom_range(0, 80)), 8'($urandom_range(40, 160)), 8'd1, 8'd2,
              12'd3, 12'd4, 12'd4095);
    run_random(100);
    wait_idle();

    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/ddm_pkg.sv
design/drowsiness_distraction_monitor_core.sv
test/tb.sv
